FILE: rtl/fol_pkg.sv
// Shared types and codes for the frequency-ordered list unit.
// Used by the controller, the datapath and the top level; no dependencies.
package fol_pkg;

    localparam int FOL_CAPACITY   = 16;
    localparam int FOL_KEY_BITS   = 32;
    localparam int FOL_COUNT_BITS = 16;

    localparam logic [2:0] FUNC_ACCESS = 3'd0;
    localparam logic [2:0] FUNC_DECAY  = 3'd1;
    localparam logic [2:0] FUNC_LOOKUP = 3'd2;
    localparam logic [2:0] FUNC_REMOVE = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NEW  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    localparam logic [1:0] ADDR_IDX = 2'd0;
    localparam logic [1:0] ADDR_INC = 2'd1;
    localparam logic [1:0] ADDR_DEC = 2'd2;

    localparam logic [1:0] WSEL_RDATA  = 2'd0;
    localparam logic [1:0] WSEL_MOVING = 2'd1;
    localparam logic [1:0] WSEL_DECAY  = 2'd2;

    localparam logic [2:0] IDX_HOLD = 3'd0;
    localparam logic [2:0] IDX_INC  = 3'd1;
    localparam logic [2:0] IDX_DEC  = 3'd2;
    localparam logic [2:0] IDX_POS  = 3'd3;
    localparam logic [2:0] IDX_FILL = 3'd4;

    localparam logic [1:0] FILL_HOLD = 2'd0;
    localparam logic [1:0] FILL_INC  = 2'd1;
    localparam logic [1:0] FILL_DEC  = 2'd2;

    localparam logic [1:0] MOV_HOLD = 2'd0;
    localparam logic [1:0] MOV_HIT  = 2'd1;
    localparam logic [1:0] MOV_NEW  = 2'd2;
    localparam logic [1:0] MOV_CAP  = 2'd3;

    localparam logic [2:0] RES_NONE  = 3'd0;
    localparam logic [2:0] RES_BAD   = 3'd1;
    localparam logic [2:0] RES_DECAY = 3'd2;
    localparam logic [2:0] RES_FULL  = 3'd3;
    localparam logic [2:0] RES_ENTRY = 3'd4;
    localparam logic [2:0] RES_PLACE = 3'd5;

    typedef struct packed {
        logic       load;
        logic [1:0] addr_sel;
        logic       we;
        logic [1:0] wsel;
        logic       waddr_dec;
        logic [2:0] idx_op;
        logic [1:0] fill_op;
        logic [1:0] mov_op;
        logic       prod_en;
        logic [2:0] res_op;
        logic       publish;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       fill_zero;
        logic       fill_full;
        logic       pos_ok;
        logic       match;
        logic       idx_zero;
        logic       idx_one;
        logic       idx_last;
        logic       prev_smaller;
        logic       out_free;
    } stat_t;

endpackage

FILE: rtl/fol_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fol_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/fol_ctrl.sv
// Sequencer for the frequency-ordered list: one command at a time.
// Depends on fol_pkg; drives the datapath through cmd_t, reads stat_t.
module fol_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  fol_pkg::stat_t  stat,
    output fol_pkg::cmd_t   cmd
);
    import fol_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_MISS     = 4'd3;
    localparam logic [3:0] S_PR_RD    = 4'd4;
    localparam logic [3:0] S_PR_CHK   = 4'd5;
    localparam logic [3:0] S_PR_PLACE = 4'd6;
    localparam logic [3:0] S_DEC_MUL  = 4'd7;
    localparam logic [3:0] S_DEC_WR   = 4'd8;
    localparam logic [3:0] S_POS_RD   = 4'd9;
    localparam logic [3:0] S_GET      = 4'd10;
    localparam logic [3:0] S_RM_MOVE  = 4'd11;
    localparam logic [3:0] S_FIN      = 4'd12;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.func)
                    FUNC_ACCESS, FUNC_LOOKUP: begin
                        if (stat.fill_zero) begin
                            state_next = S_MISS;
                        end else begin
                            cmd.addr_sel = ADDR_IDX;
                            state_next   = S_SCAN;
                        end
                    end
                    FUNC_DECAY: begin
                        if (stat.fill_zero) begin
                            cmd.res_op = RES_DECAY;
                            state_next = S_FIN;
                        end else begin
                            cmd.addr_sel = ADDR_IDX;
                            state_next   = S_DEC_MUL;
                        end
                    end
                    FUNC_REMOVE, FUNC_READ: begin
                        if (stat.pos_ok) begin
                            cmd.idx_op = IDX_POS;
                            state_next = S_POS_RD;
                        end else begin
                            cmd.res_op = RES_BAD;
                            state_next = S_FIN;
                        end
                    end
                    default: begin
                        cmd.res_op = RES_BAD;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_SCAN: begin
                if (stat.match) begin
                    if (stat.func == FUNC_LOOKUP) begin
                        cmd.res_op = RES_ENTRY;
                        state_next = S_FIN;
                    end else begin
                        cmd.mov_op = MOV_HIT;
                        state_next = stat.idx_zero ? S_PR_PLACE : S_PR_RD;
                    end
                end else if (stat.idx_last) begin
                    state_next = S_MISS;
                end else begin
                    cmd.addr_sel = ADDR_INC;
                    cmd.idx_op   = IDX_INC;
                end
            end
            S_MISS: begin
                if (stat.func == FUNC_LOOKUP) begin
                    cmd.res_op = RES_BAD;
                    state_next = S_FIN;
                end else if (stat.fill_full) begin
                    cmd.res_op = RES_FULL;
                    state_next = S_FIN;
                end else begin
                    cmd.mov_op  = MOV_NEW;
                    cmd.idx_op  = IDX_FILL;
                    cmd.fill_op = FILL_INC;
                    state_next  = stat.fill_zero ? S_PR_PLACE : S_PR_RD;
                end
            end
            S_PR_RD: begin
                cmd.addr_sel = ADDR_DEC;
                state_next   = S_PR_CHK;
            end
            S_PR_CHK: begin
                if (stat.prev_smaller) begin
                    cmd.we     = 1'b1;
                    cmd.wsel   = WSEL_RDATA;
                    cmd.idx_op = IDX_DEC;
                    state_next = stat.idx_one ? S_PR_PLACE : S_PR_RD;
                end else begin
                    state_next = S_PR_PLACE;
                end
            end
            S_PR_PLACE: begin
                cmd.we     = 1'b1;
                cmd.wsel   = WSEL_MOVING;
                cmd.res_op = RES_PLACE;
                state_next = S_FIN;
            end
            S_DEC_MUL: begin
                cmd.mov_op  = MOV_CAP;
                cmd.prod_en = 1'b1;
                state_next  = S_DEC_WR;
            end
            S_DEC_WR: begin
                cmd.we   = 1'b1;
                cmd.wsel = WSEL_DECAY;
                if (stat.idx_last) begin
                    cmd.res_op = RES_DECAY;
                    state_next = S_FIN;
                end else begin
                    cmd.addr_sel = ADDR_INC;
                    cmd.idx_op   = IDX_INC;
                    state_next   = S_DEC_MUL;
                end
            end
            S_POS_RD: begin
                cmd.addr_sel = ADDR_IDX;
                state_next   = S_GET;
            end
            S_GET: begin
                cmd.res_op = RES_ENTRY;
                if (stat.func == FUNC_READ) begin
                    state_next = S_FIN;
                end else if (stat.idx_last) begin
                    cmd.fill_op = FILL_DEC;
                    state_next  = S_FIN;
                end else begin
                    cmd.addr_sel = ADDR_INC;
                    cmd.idx_op   = IDX_INC;
                    state_next   = S_RM_MOVE;
                end
            end
            S_RM_MOVE: begin
                cmd.we        = 1'b1;
                cmd.wsel      = WSEL_RDATA;
                cmd.waddr_dec = 1'b1;
                if (stat.idx_last) begin
                    cmd.fill_op = FILL_DEC;
                    state_next  = S_FIN;
                end else begin
                    cmd.addr_sel = ADDR_INC;
                    cmd.idx_op   = IDX_INC;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/fol_dp.sv
// Datapath of the frequency-ordered list: entry RAM, index and fill
// registers, decay arithmetic and result registers. Depends on fol_pkg, fol_ram.
module fol_dp #(
    parameter int CAPACITY   = fol_pkg::FOL_CAPACITY,
    parameter int KEY_BITS   = fol_pkg::FOL_KEY_BITS,
    parameter int COUNT_BITS = fol_pkg::FOL_COUNT_BITS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [2:0]     in_func,
    input  logic [31:0]    in_key,
    input  logic [3:0]     in_position,
    input  fol_pkg::cmd_t  cmd,
    output fol_pkg::stat_t stat,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata
);
    import fol_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + COUNT_BITS;

    logic [2:0]            func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [3:0]            pos_reg;
    logic [FW-1:0]         fill_reg;
    logic [IW-1:0]         idx_reg;
    logic [KEY_BITS-1:0]   mkey_reg;
    logic [COUNT_BITS-1:0] mcnt_reg;
    logic                  hit_reg;
    logic [63:0]           prod_reg;

    logic [1:0]            res_status_reg;
    logic                  res_found_reg;
    logic [IW-1:0]         res_rank_reg;
    logic [KEY_BITS-1:0]   res_key_reg;
    logic [COUNT_BITS-1:0] res_cnt_reg;

    logic                  m_valid_reg;
    logic [63:0]           m_data_reg;

    logic [KEY_BITS-1:0]   kin;
    logic [IW-1:0]         raddr, waddr;
    logic [EW-1:0]         wdata, rdata;
    logic [KEY_BITS-1:0]   rkey;
    logic [COUNT_BITS-1:0] rcnt;
    logic [COUNT_BITS-1:0] quo, rem, dec_cnt;
    logic [31:0]           okey;
    logic [15:0]           ocnt;

    always_comb begin
        kin = '0;
        for (int b = 0; b < KEY_BITS && b < 32; b++) begin
            kin[b] = in_key[b];
        end
    end

    assign rkey = rdata[EW-1:COUNT_BITS];
    assign rcnt = rdata[COUNT_BITS-1:0];

    always_comb begin
        case (cmd.addr_sel)
            ADDR_INC: raddr = idx_reg + IW'(1);
            ADDR_DEC: raddr = idx_reg - IW'(1);
            default:  raddr = idx_reg;
        endcase
    end

    assign waddr = cmd.waddr_dec ? (idx_reg - IW'(1)) : idx_reg;

    // floor(9c/10) = 9q + (r ? r-1 : 0), with q, r from c/10
    assign quo     = COUNT_BITS'(prod_reg >> 35);
    assign rem     = mcnt_reg - COUNT_BITS'(quo * COUNT_BITS'(10));
    assign dec_cnt = COUNT_BITS'(quo * COUNT_BITS'(9))
                   + ((rem != '0) ? (rem - COUNT_BITS'(1)) : '0);

    always_comb begin
        case (cmd.wsel)
            WSEL_MOVING: wdata = {mkey_reg, mcnt_reg};
            WSEL_DECAY:  wdata = {mkey_reg, dec_cnt};
            default:     wdata = rdata;
        endcase
    end

    fol_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .aclk  (aclk),
        .we    (cmd.we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        stat.func         = func_reg;
        stat.fill_zero    = (fill_reg == '0);
        stat.fill_full    = (32'(fill_reg) == 32'(CAPACITY));
        stat.pos_ok       = (32'(pos_reg) < 32'(fill_reg));
        stat.match        = (rkey == key_reg);
        stat.idx_zero     = (idx_reg == '0);
        stat.idx_one      = (idx_reg == IW'(1));
        stat.idx_last     = ((FW'(idx_reg) + FW'(1)) == fill_reg);
        stat.prev_smaller = (rcnt < mcnt_reg);
        stat.out_free     = !m_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (cmd.fill_op)
                FILL_INC: fill_reg <= fill_reg + FW'(1);
                FILL_DEC: fill_reg <= fill_reg - FW'(1);
                default:  fill_reg <= fill_reg;
            endcase
            if (cmd.publish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            key_reg  <= kin;
            pos_reg  <= in_position;
        end
        if (cmd.load) begin
            idx_reg <= '0;
        end else begin
            case (cmd.idx_op)
                IDX_INC:  idx_reg <= idx_reg + IW'(1);
                IDX_DEC:  idx_reg <= idx_reg - IW'(1);
                IDX_POS:  idx_reg <= IW'(pos_reg);
                IDX_FILL: idx_reg <= IW'(fill_reg);
                default:  idx_reg <= idx_reg;
            endcase
        end
        case (cmd.mov_op)
            MOV_HIT: begin
                mkey_reg <= rkey;
                mcnt_reg <= (rcnt == '1) ? rcnt : rcnt + COUNT_BITS'(1);
                hit_reg  <= 1'b1;
            end
            MOV_NEW: begin
                mkey_reg <= key_reg;
                mcnt_reg <= COUNT_BITS'(1);
                hit_reg  <= 1'b0;
            end
            MOV_CAP: begin
                mkey_reg <= rkey;
                mcnt_reg <= rcnt;
            end
            default: begin
                mkey_reg <= mkey_reg;
            end
        endcase
        if (cmd.prod_en) begin
            prod_reg <= 64'(32'(rcnt)) * 64'(32'hCCCC_CCCD);
        end
        case (cmd.res_op)
            RES_BAD, RES_DECAY: begin
                res_status_reg <= (cmd.res_op == RES_BAD) ? ST_BAD : ST_DONE;
                res_found_reg  <= 1'b0;
                res_rank_reg   <= '0;
                res_key_reg    <= '0;
                res_cnt_reg    <= '0;
            end
            RES_FULL: begin
                res_status_reg <= ST_FULL;
                res_found_reg  <= 1'b0;
                res_rank_reg   <= '0;
                res_key_reg    <= key_reg;
                res_cnt_reg    <= '0;
            end
            RES_ENTRY: begin
                res_status_reg <= ST_DONE;
                res_found_reg  <= (func_reg == FUNC_LOOKUP);
                res_rank_reg   <= idx_reg;
                res_key_reg    <= rkey;
                res_cnt_reg    <= rcnt;
            end
            RES_PLACE: begin
                res_status_reg <= hit_reg ? ST_DONE : ST_NEW;
                res_found_reg  <= hit_reg;
                res_rank_reg   <= idx_reg;
                res_key_reg    <= mkey_reg;
                res_cnt_reg    <= mcnt_reg;
            end
            default: begin
                res_status_reg <= res_status_reg;
            end
        endcase
        if (cmd.publish) begin
            m_data_reg <= {4'd0, 5'(fill_reg), ocnt, okey, 4'(res_rank_reg),
                           res_found_reg, res_status_reg};
        end
    end

    always_comb begin
        okey = '0;
        for (int b = 0; b < KEY_BITS && b < 32; b++) begin
            okey[b] = res_key_reg[b];
        end
        ocnt = '0;
        for (int b = 0; b < COUNT_BITS && b < 16; b++) begin
            ocnt[b] = res_cnt_reg[b];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: rtl/frequency_ordered_list_unit.sv
// Frequency-ordered list unit: top level joining sequencer and datapath.
// Depends on fol_pkg, fol_ctrl, fol_dp (and fol_ram below it).
//
// Keeps up to CAPACITY key/count entries in one RAM, highest count first,
// ties in arrival order. One command is worked at a time, stepping through
// the entry RAM one location at a time: access and lookup scan from rank 0
// at one cycle per entry, then an access bubbles the entry up, reading the
// entry one rank higher and checking it before each move; remove shifts the
// tail one entry a cycle; decay works each entry by a reciprocal multiply,
// then a write back. The entry RAM has a single read and a single write
// port, and the result step waits while the output register still holds an
// unaccepted item. A new item is taken while the previous result still
// waits on the output register.
module frequency_ordered_list_unit #(
    parameter int CAPACITY   = fol_pkg::FOL_CAPACITY,
    parameter int KEY_BITS   = fol_pkg::FOL_KEY_BITS,
    parameter int COUNT_BITS = fol_pkg::FOL_COUNT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[2:0], key[34:3], position[38:35], zero pad
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], found[2], rank[6:3], entry_key[38:7],
    // entry_count[54:39], occupancy[59:55], zero pad
    output logic [63:0] m_tdata
);
    import fol_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fol_dp #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_func     (s_tdata[2:0]),
        .in_key      (s_tdata[34:3]),
        .in_position (s_tdata[38:35]),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sequencer idle right after taking an item");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[59:55]) <= 32'(CAPACITY))
        else $error("occupancy above capacity");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == ST_FULL |->
            !m_tdata[2] && 32'(m_tdata[59:55]) == 32'(CAPACITY))
        else $error("table-full result with room left");

    a_single_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> !(cmd.we || cmd.load))
        else $error("publish overlaps other work");

endmodule

FILE: sim/frequency_ordered_list_checker.sv
// Checker for the frequency-ordered list unit: watches both stream channels,
// keeps its own copy of the key/count table and compares every result item.
// Depends on fol_pkg.
`timescale 1ns / 1ps
module frequency_ordered_list_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    import fol_pkg::*;

    localparam int CAP = FOL_CAPACITY;

    // highest field first, so status lands in the lowest bits
    typedef struct packed {
        logic [4:0]  occupancy;
        logic [15:0] entry_count;
        logic [31:0] entry_key;
        logic [3:0]  rank;
        logic        found;
        logic [1:0]  status;
    } outcome_t;

    logic [31:0] table_key [CAP];
    logic [15:0] table_cnt [CAP];
    int          table_fill;
    outcome_t    outcome_q[$];

    assign pending = outcome_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int bubble_up(input int i);
        logic [31:0] k;
        logic [15:0] c;
        while (i > 0 && table_cnt[i-1] < table_cnt[i]) begin
            k = table_key[i-1]; c = table_cnt[i-1];
            table_key[i-1] = table_key[i]; table_cnt[i-1] = table_cnt[i];
            table_key[i] = k; table_cnt[i] = c;
            i--;
        end
        return i;
    endfunction

    function automatic outcome_t apply_command(input logic [2:0] func, input logic [31:0] key,
                                               input logic [3:0] pos);
        outcome_t r;
        int at;
        r = '0;
        r.status = ST_BAD;
        at = -1;
        if (func == FUNC_ACCESS || func == FUNC_LOOKUP)
            for (int i = table_fill - 1; i >= 0; i--)
                if (table_key[i] == key) at = i;
        case (func)
            FUNC_ACCESS: begin
                if (at >= 0) begin
                    if (table_cnt[at] != 16'hFFFF) table_cnt[at]++;
                    at = bubble_up(at);
                    r.status = ST_DONE; r.found = 1'b1;
                end else if (table_fill < CAP) begin
                    table_key[table_fill] = key;
                    table_cnt[table_fill] = 16'd1;
                    table_fill++;
                    at = bubble_up(table_fill - 1);
                    r.status = ST_NEW;
                end else begin
                    r.status = ST_FULL; r.entry_key = key;
                end
                if (at >= 0) begin
                    r.rank = 4'(at); r.entry_key = table_key[at];
                    r.entry_count = table_cnt[at];
                end
            end
            FUNC_DECAY: begin
                for (int i = 0; i < table_fill; i++)
                    table_cnt[i] = 16'((32'(table_cnt[i]) * 9) / 10);
                r.status = ST_DONE;
            end
            FUNC_LOOKUP: begin
                if (at >= 0) begin
                    r.status = ST_DONE; r.found = 1'b1; r.rank = 4'(at);
                    r.entry_key = table_key[at]; r.entry_count = table_cnt[at];
                end
            end
            FUNC_REMOVE, FUNC_READ: begin
                if (pos < table_fill) begin
                    r.status = ST_DONE; r.rank = pos;
                    r.entry_key = table_key[pos]; r.entry_count = table_cnt[pos];
                    if (func == FUNC_REMOVE) begin
                        for (int i = pos; i + 1 < table_fill; i++) begin
                            table_key[i] = table_key[i+1]; table_cnt[i] = table_cnt[i+1];
                        end
                        table_fill--;
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = 5'(table_fill);
        return r;
    endfunction

    always @(posedge aclk) begin
        outcome_t got, want;
        if (!aresetn) begin
            table_fill <= 0;
            fail_count <= 0;
            outcome_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                outcome_q.push_back(apply_command(s_tdata[2:0], s_tdata[34:3], s_tdata[38:35]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[59:0];
                if (m_tdata[63:60] != 4'd0) report("pad", 32'(m_tdata[63:60]), 32'd0);
                if (outcome_q.size() == 0) begin
                    report("unexpected item", got.entry_key, 32'd0);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status != want.status)
                        report("status", 32'(got.status), 32'(want.status));
                    if (got.found != want.found)
                        report("found", 32'(got.found), 32'(want.found));
                    if (got.rank != want.rank)
                        report("rank", 32'(got.rank), 32'(want.rank));
                    if (got.entry_key != want.entry_key)
                        report("entry_key", got.entry_key, want.entry_key);
                    if (got.entry_count != want.entry_count)
                        report("entry_count", 32'(got.entry_count), 32'(want.entry_count));
                    if (got.occupancy != want.occupancy)
                        report("occupancy", 32'(got.occupancy), 32'(want.occupancy));
                end
            end
        end
    end
endmodule

FILE: sim/frequency_ordered_list_unit_tb.sv
// Testbench top for the frequency-ordered list unit: drives commands with
// random gaps and stalls; the checker predicts and compares.
// Depends on fol_pkg, frequency_ordered_list_unit, frequency_ordered_list_checker.
`timescale 1ns / 1ps
module frequency_ordered_list_unit_tb;
    import fol_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    logic [31:0] hot_keys [8];

    always #5 aclk = ~aclk;

    frequency_ordered_list_unit dut (.*);
    frequency_ordered_list_checker u_check (.*);

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // leaves tvalid high after the accept; the next call or the caller drops it
    task automatic send_item(input logic [2:0] func, input logic [31:0] key,
                             input logic [3:0] pos);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata  <= {1'b0, pos, key, func};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver stalls; one long hold-off while the sender keeps offering items
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            if ($urandom_range(0, 99) < 3) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(10, 50)) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int p;
        logic [2:0] f;
        logic [31:0] k;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (hot_keys[i]) hot_keys[i] = $urandom();
        hot_keys[0] = 32'h0; hot_keys[1] = 32'hFFFF_FFFF;
        // directed
        send_item(FUNC_READ, 32'd0, 4'd0);
        send_item(FUNC_REMOVE, 32'd0, 4'd15);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 4'd0);
        send_item(FUNC_DECAY, 32'd0, 4'd0);
        send_item(FUNC_ACCESS, 32'h0, 4'd0);
        send_item(FUNC_ACCESS, 32'hFFFF_FFFF, 4'd0);
        send_item(FUNC_ACCESS, 32'hFFFF_FFFF, 4'd0);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 4'd15);
        for (int i = 0; i < 16; i++) send_item(FUNC_ACCESS, 32'h100 + i, 4'd0);
        send_item(FUNC_READ, 32'd0, 4'd15);
        send_item(3'd5, 32'hA5A5_A5A5, 4'd9);
        send_item(3'd7, 32'h5A5A_5A5A, 4'd6);
        send_item(FUNC_REMOVE, 32'd0, 4'd15);
        send_item(FUNC_DECAY, 32'd0, 4'd0);
        hold_off = 1'b1;
        for (int i = 0; i < 8; i++) send_item(FUNC_REMOVE, 32'd0, 4'd0);
        send_item(FUNC_ACCESS, 32'hFFFF_FFFF, 4'd0);
        send_item(FUNC_DECAY, 32'd0, 4'd0);
        // random
        for (int n = 0; n < 1150; n++) begin
            p = $urandom_range(0, 99);
            k = ($urandom_range(0, 3) != 0) ? hot_keys[$urandom_range(0, 7)]
                                            : 32'($urandom_range(0, 23));
            if (p < 3) k = $urandom();
            if (p < 55) f = FUNC_ACCESS;
            else if (p < 62) f = FUNC_DECAY;
            else if (p < 75) f = FUNC_LOOKUP;
            else if (p < 85) f = FUNC_REMOVE;
            else if (p < 97) f = FUNC_READ;
            else f = 3'($urandom_range(5, 7));
            send_item(f, k, 4'($urandom_range(0, 15)));
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: sim.f
rtl/fol_pkg.sv
rtl/fol_ram.sv
rtl/fol_ctrl.sv
rtl/fol_dp.sv
rtl/frequency_ordered_list_unit.sv
sim/frequency_ordered_list_checker.sv
sim/frequency_ordered_list_unit_tb.sv
